>>> rtl/node_trust_reputation_table_unit_defines.svh
// ----------------------------------------------------------------------------
// node_trust_reputation_table_unit_defines
// Assertion macros shared by the trust table RTL.
// ----------------------------------------------------------------------------
`ifndef NODE_TRUST_REPUTATION_TABLE_UNIT_DEFINES_SVH
`define NODE_TRUST_REPUTATION_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NTRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntrt: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define NTRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntrt: next-cycle check failed");

`endif

>>> rtl/ntrt_pkg.sv
// ----------------------------------------------------------------------------
// ntrt_pkg
// Types and constants of the node trust reputation table.
// ----------------------------------------------------------------------------
`default_nettype none

package ntrt_pkg;

   localparam int NODE_COUNT_DEF  = 256;
   localparam int SCORE_SCALE_DEF = 100;

   localparam int SCORE_W  = 7;
   localparam int STREAK_W = 8;
   localparam int NODE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int PEN_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

   // request kinds
   localparam logic REQ_EVENT = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // event kinds
   localparam logic [KIND_W-1:0] EV_GOOD    = 2'd0;
   localparam logic [KIND_W-1:0] EV_REPLAY  = 2'd1;
   localparam logic [KIND_W-1:0] EV_TAMPER  = 2'd2;
   localparam logic [KIND_W-1:0] EV_INVALID = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLAY     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAMPER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ELIMINATE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSPICIOUS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT      = 3'd6;

   // register reset values
   localparam logic [SCORE_W-1:0]  WEIGHT_RST     = 7'd80;
   localparam logic [PEN_W-1:0]    REPLAY_RST     = 8'd40;
   localparam logic [PEN_W-1:0]    TAMPER_RST     = 8'd60;
   localparam logic [PEN_W-1:0]    INVALID_RST    = 8'd30;
   localparam logic [SCORE_W-1:0]  ELIMINATE_RST  = 7'd30;
   localparam logic [SCORE_W-1:0]  SUSPICIOUS_RST = 7'd50;
   localparam logic [STREAK_W-1:0] LIMIT_RST      = 8'd3;

   typedef struct packed {
      logic              req_type;
      logic [NODE_W-1:0] node_id;
      logic [KIND_W-1:0] event_kind;
   } req_payload_type;

   typedef struct packed {
      logic [SCORE_W-1:0]  trust_level;
      logic [STREAK_W-1:0] streak_count;
      logic                is_banned;
      logic                newly_banned;
      logic                alert_raised;
   } rsp_payload_type;

   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [STREAK_W-1:0] streak;
      logic                banned;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/node_trust_reputation_table_unit.sv
// ----------------------------------------------------------------------------
// node_trust_reputation_table_unit
// Per-node trust table: moving-average score, bad-event streak, blacklist.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per node event (req_type 0) or entry query (1).
//   rsp_*  : one response per request with the entry after the request.
//   csr_*  : register writes, always ready; write only while the block idles.
// Sequence: an event runs a table read, two multiply steps for the weighted
//   sum, one reciprocal multiply for the divide by SCORE_SCALE, all on one
//   shared multiplier, then write-back. A query or an event on a blacklisted
//   node skips the behavior multiply and the divide. node_id beyond the table
//   folds through a combinational constant lookup at accept.
// Flow: one request in flight at a time; req_ready returns in the same cycle
//   that rsp_valid rises, so a new request is taken only once the last one
//   has reached the response register.
// Reset: registers take their reset values, then the table is swept one
//   entry per cycle to score SCORE_SCALE, streak 0, not banned; req_ready
//   stays low during the sweep.
// Stall: the response sits in an output register; a new request can be
//   accepted while it waits, and write-back of the next one holds until the
//   response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_trust_reputation_table_unit_defines.svh"

module node_trust_reputation_table_unit #(
   parameter int NODE_COUNT  = ntrt_pkg::NODE_COUNT_DEF,
   parameter int SCORE_SCALE = ntrt_pkg::SCORE_SCALE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire ntrt_pkg::req_payload_type         req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output ntrt_pkg::rsp_payload_type              rsp_payload,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ntrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ntrt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int ACC_W    = 2 * ntrt_pkg::SCORE_W;
   localparam int ID_SPAN  = 1 << ntrt_pkg::NODE_W;
   // divide by the scale as a multiply by its rounded-up reciprocal; this shift
   // is exact for every sum below 2^ACC_W with any scale from 2 to 2^SCORE_W-1
   localparam int RECIP_SH = ACC_W + ntrt_pkg::SCORE_W;
   localparam int PROD_W   = ACC_W + RECIP_SH;

   localparam logic [IDX_W-1:0]            LAST_IDX = IDX_W'(NODE_COUNT - 1);
   localparam logic [ntrt_pkg::SCORE_W-1:0] SCALE_C = ntrt_pkg::SCORE_W'(SCORE_SCALE);
   localparam logic [RECIP_SH-1:0]         RECIP_C  =
      RECIP_SH'(((1 << RECIP_SH) + SCORE_SCALE - 1) / SCORE_SCALE);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_MULOLD = 3'd3;
   localparam logic [2:0] ST_MULBEH = 3'd4;
   localparam logic [2:0] ST_DIVIDE = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   // ---------------------------------------------------------------- registers
   logic [2:0]                       state_ff, state_in;
   logic                             sweep_ff, sweep_in;
   logic [IDX_W-1:0]                 sweep_cnt_ff, sweep_cnt_in;
   ntrt_pkg::req_payload_type        item_ff, item_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [ACC_W-1:0]                 acc_ff, acc_in;
   logic [ntrt_pkg::SCORE_W-1:0]     quo_ff, quo_in;
   logic                             upd_ff, upd_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ntrt_pkg::rsp_payload_type        rsp_ff, rsp_in;
   ntrt_pkg::entry_type              rd_ff;

   logic [ntrt_pkg::SCORE_W-1:0]  weight_ff, weight_in;
   logic [ntrt_pkg::PEN_W-1:0]    replay_ff, replay_in;
   logic [ntrt_pkg::PEN_W-1:0]    tamper_ff, tamper_in;
   logic [ntrt_pkg::PEN_W-1:0]    invalid_ff, invalid_in;
   logic [ntrt_pkg::SCORE_W-1:0]  elim_ff, elim_in;
   logic [ntrt_pkg::SCORE_W-1:0]  susp_ff, susp_in;
   logic [ntrt_pkg::STREAK_W-1:0] limit_ff, limit_in;

   ntrt_pkg::entry_type mem [NODE_COUNT];

   // ------------------------------------------------------------ datapath wires
   logic                          req_fire;
   logic                          rsp_free;
   logic [IDX_W-1:0]              node_map [ID_SPAN];
   logic [IDX_W-1:0]              node_addr;
   logic [ntrt_pkg::SCORE_W-1:0]  weight_c;
   logic [ntrt_pkg::PEN_W-1:0]    penalty;
   logic [ntrt_pkg::SCORE_W-1:0]  behavior;
   logic [ACC_W-1:0]              mul_a;
   logic [RECIP_SH-1:0]           mul_b;
   logic [PROD_W-1:0]             product;
   logic [ACC_W-1:0]              quo_full;
   logic [ntrt_pkg::STREAK_W-1:0] streak_new;
   logic                          ban_now;
   logic                          alert_bad;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   ntrt_pkg::entry_type           wr_data;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !sweep_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign node_addr = idx_ff;

   // fold every node id onto the table with a constant lookup
   for (genvar g = 0; g < ID_SPAN; g++) begin : g_node_map
      assign node_map[g] = IDX_W'(g % NODE_COUNT);
   end

   // clamp the weight to the scale
   assign weight_c = (weight_ff > SCALE_C) ? SCALE_C : weight_ff;

   // event penalty and behavior value
   always_comb begin
      unique case (item_ff.event_kind)
         ntrt_pkg::EV_REPLAY:  penalty = replay_ff;
         ntrt_pkg::EV_TAMPER:  penalty = tamper_ff;
         ntrt_pkg::EV_INVALID: penalty = invalid_ff;
         default:              penalty = '0;
      endcase
   end

   assign behavior = (penalty >= {1'b0, SCALE_C}) ? '0
                     : (SCALE_C - penalty[ntrt_pkg::SCORE_W-1:0]);

   // shared multiplier: old score term, behavior term, then the reciprocal
   always_comb begin
      unique case (state_ff)
         ST_MULOLD: begin
            mul_a = {{ntrt_pkg::SCORE_W{1'b0}}, weight_c};
            mul_b = {{(RECIP_SH - ntrt_pkg::SCORE_W){1'b0}}, rd_ff.score};
         end
         ST_MULBEH: begin
            mul_a = {{ntrt_pkg::SCORE_W{1'b0}}, SCALE_C - weight_c};
            mul_b = {{(RECIP_SH - ntrt_pkg::SCORE_W){1'b0}}, behavior};
         end
         default: begin
            mul_a = acc_ff;
            mul_b = RECIP_C;
         end
      endcase
   end

   assign product  = {{RECIP_SH{1'b0}}, mul_a} * {{ACC_W{1'b0}}, mul_b};
   assign quo_full = product[RECIP_SH +: ACC_W];

   // streak, blacklist and alert from the new score
   always_comb begin
      if (item_ff.event_kind == ntrt_pkg::EV_GOOD) begin
         streak_new = '0;
      end else if (quo_ff <= elim_ff) begin
         streak_new = (rd_ff.streak == ntrt_pkg::STREAK_MAX) ? rd_ff.streak
                      : rd_ff.streak + 8'd1;
      end else begin
         streak_new = (rd_ff.streak == '0) ? '0 : rd_ff.streak - 8'd1;
      end
   end

   assign ban_now   = (streak_new >= limit_ff);
   assign alert_bad = (item_ff.event_kind != ntrt_pkg::EV_GOOD) && (quo_ff <= susp_ff);

   // table write port: reset sweep or write-back
   always_comb begin
      if (sweep_ff) begin
         wr_en   = 1'b1;
         wr_addr = sweep_cnt_ff;
         wr_data = '{score: SCALE_C, streak: '0, banned: 1'b0};
      end else begin
         wr_en   = (state_ff == ST_FINISH) && rsp_free && upd_ff;
         wr_addr = node_addr;
         wr_data = '{score: quo_ff, streak: streak_new, banned: ban_now};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_READ) begin
         rd_ff <= mem[node_addr];
      end
   end

   // ------------------------------------------------------------------ control
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // advance the reset sweep
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (sweep_cnt_ff == LAST_IDX) begin
            sweep_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in  = req_payload;
               idx_in   = node_map[req_payload.node_id];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MULOLD;
         end
         ST_MULOLD: begin
            upd_in = (item_ff.req_type == ntrt_pkg::REQ_EVENT) && !rd_ff.banned;
            acc_in = product[ACC_W-1:0];
            if ((item_ff.req_type == ntrt_pkg::REQ_EVENT) && !rd_ff.banned) begin
               state_in = ST_MULBEH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MULBEH: begin
            acc_in   = acc_ff + product[ACC_W-1:0];
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // saturate the quotient to the score width
            quo_in   = (|quo_full[ACC_W-1:ntrt_pkg::SCORE_W]) ? '1
                       : quo_full[ntrt_pkg::SCORE_W-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (upd_ff) begin
                  rsp_in = '{trust_level:  quo_ff,
                             streak_count: streak_new,
                             is_banned:    ban_now,
                             newly_banned: ban_now,
                             alert_raised: alert_bad || ban_now};
               end else begin
                  rsp_in = '{trust_level:  rd_ff.score,
                             streak_count: rd_ff.streak,
                             is_banned:    rd_ff.banned,
                             newly_banned: 1'b0,
                             alert_raised: 1'b0};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      weight_in  = weight_ff;
      replay_in  = replay_ff;
      tamper_in  = tamper_ff;
      invalid_in = invalid_ff;
      elim_in    = elim_ff;
      susp_in    = susp_ff;
      limit_in   = limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ntrt_pkg::CSR_WEIGHT:     weight_in  = csr_wdata[ntrt_pkg::SCORE_W-1:0];
            ntrt_pkg::CSR_REPLAY:     replay_in  = csr_wdata;
            ntrt_pkg::CSR_TAMPER:     tamper_in  = csr_wdata;
            ntrt_pkg::CSR_INVALID:    invalid_in = csr_wdata;
            ntrt_pkg::CSR_ELIMINATE:  elim_in    = csr_wdata[ntrt_pkg::SCORE_W-1:0];
            ntrt_pkg::CSR_SUSPICIOUS: susp_in    = csr_wdata[ntrt_pkg::SCORE_W-1:0];
            ntrt_pkg::CSR_LIMIT:      limit_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         weight_ff    <= ntrt_pkg::WEIGHT_RST;
         replay_ff    <= ntrt_pkg::REPLAY_RST;
         tamper_ff    <= ntrt_pkg::TAMPER_RST;
         invalid_ff   <= ntrt_pkg::INVALID_RST;
         elim_ff      <= ntrt_pkg::ELIMINATE_RST;
         susp_ff      <= ntrt_pkg::SUSPICIOUS_RST;
         limit_ff     <= ntrt_pkg::LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
         weight_ff    <= weight_in;
         replay_ff    <= replay_in;
         tamper_ff    <= tamper_in;
         invalid_ff   <= invalid_in;
         elim_ff      <= elim_in;
         susp_ff      <= susp_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      rsp_ff  <= rsp_in;
   end

   // --------------------------------------------------------------- assertions
   // one request in flight: an accept closes the request port next cycle
   `NTRT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_ready)
   // a node blacklisted by this request is reported banned and alerted
   `NTRT_ASSERT_NOW(a_newly_banned, clock, reset, rsp_valid_ff && rsp_ff.newly_banned,
      rsp_ff.is_banned && rsp_ff.alert_raised)
   // the moving average never leaves the score range
   `NTRT_ASSERT_NOW(a_score_range, clock, reset, rsp_valid_ff, rsp_ff.trust_level <= SCALE_C)
   // no request is taken while the table is being swept
   `NTRT_ASSERT_NOW(a_no_accept_sweep, clock, reset, sweep_ff, state_ff == ST_IDLE)

endmodule

`default_nettype wire
